>>> design/tlc_pkg.sv
// ----------------------------------------------------------------------------
// tlc_pkg: shared types and constants for the tone table composer
// Action codes, curve constants and the bundles passed between modules.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam logic [2:0] ACT_IDENTITY       = 3'd0;
  localparam logic [2:0] ACT_INVERT         = 3'd1;
  localparam logic [2:0] ACT_ADD_BRIGHT     = 3'd2;
  localparam logic [2:0] ACT_REDUCE_BRIGHT  = 3'd3;
  localparam logic [2:0] ACT_ADD_CONTRAST   = 3'd4;
  localparam logic [2:0] ACT_SCALE_CONTRAST = 3'd5;
  localparam logic [2:0] ACT_LOOKUP         = 3'd6;

  localparam logic [7:0]         LEVEL_MAX      = 8'd255;
  localparam logic [7:0]         CONTRAST_PIVOT = 8'd127;
  localparam logic [8:0]         SCALE_CENTER   = 9'd128;
  localparam logic signed [17:0] SCALE_BIAS     = 18'sd12800;

  // floor(n / 100) == (n * 5243) >> 19 for 0 <= n < 43699, larger n only clamps
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic [2:0]        action;
    logic signed [8:0] amount;
  } curve_cmd_t;

  typedef struct packed {
    logic       we;
    logic [8:0] addr;
    logic [7:0] data;
  } tlc_wr_t;

endpackage

>>> design/tlc_curve.sv
// ----------------------------------------------------------------------------
// tlc_curve: shared curve unit
// Two-stage pipeline mapping an entry index to its clamped curve level.
// ----------------------------------------------------------------------------
module tlc_curve import tlc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  curve_cmd_t cmd,
  input  logic       in_valid,
  input  logic [7:0] in_idx,
  output logic       out_valid,
  output logic [7:0] out_idx,
  output logic [7:0] out_level
);

  logic signed [17:0] lvl;
  logic signed [17:0] amt;
  logic signed [8:0]  half;
  logic signed [8:0]  center_gap;
  logic signed [17:0] prod;
  logic signed [17:0] wide;

  logic               s1_valid;
  logic [7:0]         s1_idx;
  logic               s1_scale;
  logic signed [17:0] s1_wide;

  logic [29:0]        qprod;
  logic [10:0]        quot;
  logic [7:0]         level_next;

  // stage 1: raw curve value, scale product
  always_comb begin
    lvl  = $signed({10'd0, in_idx});
    amt  = 18'(cmd.amount);
    half = (cmd.amount + $signed({8'd0, cmd.amount[8]})) >>> 1;
    center_gap = $signed(SCALE_CENTER - {1'b0, in_idx});
    prod = 18'(center_gap) * 18'(cmd.amount);
    case (cmd.action)
      ACT_INVERT:        wide = $signed({10'd0, LEVEL_MAX}) - lvl;
      ACT_ADD_BRIGHT:    wide = lvl + amt;
      ACT_REDUCE_BRIGHT: wide = lvl - amt;
      ACT_ADD_CONTRAST: begin
        if (in_idx < CONTRAST_PIVOT) begin
          wide = lvl - 18'(half);
        end else begin
          wide = lvl + 18'(half);
        end
      end
      default:           wide = SCALE_BIAS - prod;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_idx   <= in_idx;
    s1_scale <= (cmd.action == ACT_SCALE_CONTRAST);
    s1_wide  <= wide;
  end

  // stage 2: divide by 100 through reciprocal, clamp
  always_comb begin
    qprod = {13'd0, s1_wide[16:0]} * {17'd0, RECIP_100};
    quot  = qprod[RECIP_SHIFT +: 11];
    if (s1_wide[17]) begin
      level_next = 8'd0;
    end else if (s1_scale) begin
      level_next = (quot > 11'(LEVEL_MAX)) ? LEVEL_MAX : quot[7:0];
    end else begin
      level_next = (s1_wide > $signed({10'd0, LEVEL_MAX})) ? LEVEL_MAX : s1_wide[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid;
    end
    out_idx   <= s1_idx;
    out_level <= level_next;
  end

endmodule

>>> design/tlc_table.sv
// ----------------------------------------------------------------------------
// tlc_table: two-bank tone table storage
// 512 x 8 memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tlc_table import tlc_pkg::*; (
  input  logic       clk,
  input  tlc_wr_t    wr,
  input  logic [8:0] raddr,
  output logic [7:0] rdata
);

  logic [7:0] mem [0:511];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/tone_lut_compose_unit.sv
// ----------------------------------------------------------------------------
// tone_lut_compose_unit: composite 8-bit tone table
// Composes tone curves onto a 256-entry table and maps pixels through it.
// ----------------------------------------------------------------------------
// A transaction is taken at a rising edge with start high and busy low;
// action, amount and pixel_in are sampled there.
// Lookup: pixel_out is shown for one cycle with done high, in the cycle
// right after the transaction; busy stays low, so lookups go back to back.
// Identity reset and the unused action code give no result; busy stays low.
// Curve actions walk all 256 entries through the curve pipeline (two
// stages), a table read and a write into the inactive bank, one entry a
// cycle; busy stays high until the last entry is written.
// The walk length is set by the single memory write port.
// Reset (rst, synchronous) makes the table the identity at once, with no
// clearing pass: an identity flag stands in for the table contents until
// the first curve is composed. The receiver cannot stall: done is a
// one-cycle strobe and must be taken when it appears.
// ----------------------------------------------------------------------------
module tone_lut_compose_unit import tlc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        action,
  input  logic signed [8:0] amount,
  input  logic [7:0]        pixel_in,
  output logic              done,
  output logic [7:0]        pixel_out
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state;
  logic       bank;
  logic       ident;
  logic [7:0] walk_index;
  curve_cmd_t cmd;

  logic       accept;
  logic       is_adjust;

  logic       c_valid;
  logic [7:0] c_idx;
  logic [7:0] c_level;

  logic       s3_valid;
  logic [7:0] s3_idx;
  logic [7:0] s3_level;

  logic       look_ident;
  logic [7:0] look_pix;

  tlc_wr_t    wr;
  logic [8:0] raddr;
  logic [7:0] rdata;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign is_adjust = (action == ACT_INVERT) || (action == ACT_ADD_BRIGHT) ||
                     (action == ACT_REDUCE_BRIGHT) || (action == ACT_ADD_CONTRAST) ||
                     (action == ACT_SCALE_CONTRAST);

  tlc_curve u_curve (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_valid  (state == ST_WALK),
    .in_idx    (walk_index),
    .out_valid (c_valid),
    .out_idx   (c_idx),
    .out_level (c_level)
  );

  assign raddr   = busy ? {bank, c_level} : {bank, pixel_in};
  assign wr.we   = s3_valid;
  assign wr.addr = {~bank, s3_idx};
  assign wr.data = ident ? s3_level : rdata;

  tlc_table u_table (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      bank       <= 1'b0;
      ident      <= 1'b1;
      walk_index <= 8'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && action == ACT_IDENTITY) begin
            ident <= 1'b1;
          end else if (accept && is_adjust) begin
            walk_index <= 8'd0;
            state      <= ST_WALK;
          end
        end
        ST_WALK: begin
          walk_index <= walk_index + 8'd1;
          if (walk_index == LEVEL_MAX) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (s3_valid && !c_valid) begin
            bank  <= ~bank;
            ident <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.action <= action;
      cmd.amount <= amount;
    end
  end

  // read data lines up with this stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= c_valid;
    end
    s3_idx   <= c_idx;
    s3_level <= c_level;
  end

  // lookup result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept && (action == ACT_LOOKUP);
    end
    if (accept) begin
      look_ident <= ident;
      look_pix   <= pixel_in;
    end
  end

  assign pixel_out = look_ident ? look_pix : rdata;

  a_done_from_lookup: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && action == ACT_LOOKUP))
    else $error("result strobe without a lookup transaction");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a walk is running");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> busy)
    else $error("table write outside a walk");

  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && walk_index == LEVEL_MAX) |=> (state == ST_DRAIN && walk_index == 8'd0))
    else $error("walk did not finish after the last entry");

endmodule
